// ===== hdl/lps_pkg.sv =====
// lps_pkg: shared types and constants for the line pixel stepper
// used by the controller, the datapath, the top level and the checker
// no dependencies
package lps_pkg;

  localparam int COORD_BITS  = 12;
  localparam int CFG_BITS    = 12;
  localparam int CMP_BITS    = (COORD_BITS > CFG_BITS) ? COORD_BITS : CFG_BITS;
  localparam int S_DATA_BITS = ((4 * COORD_BITS + 7) / 8) * 8;
  localparam int M_DATA_BITS = ((2 * COORD_BITS + 2 + 7) / 8) * 8;

  // output word bit positions
  localparam int M_PIX_INSIDE_BIT  = 2 * COORD_BITS;
  localparam int M_LINE_INSIDE_BIT = 2 * COORD_BITS + 1;

  localparam logic FUNC_LOAD = 1'b0;
  localparam logic FUNC_STEP = 1'b1;

  localparam logic REG_CANVAS_WIDTH  = 1'b0;
  localparam logic REG_CANVAS_HEIGHT = 1'b1;

  localparam logic [CFG_BITS-1:0] CANVAS_WIDTH_RESET  = CFG_BITS'(640);
  localparam logic [CFG_BITS-1:0] CANVAS_HEIGHT_RESET = CFG_BITS'(480);

  typedef logic signed [COORD_BITS-1:0] coord_t;

  typedef enum logic {
    LN_IDLE,
    LN_ACTIVE
  } line_state_t;

  typedef struct packed {
    logic load;
    logic step;
  } dp_cmd_t;

  typedef struct packed {
    logic last;
  } dp_status_t;

endpackage

// ===== hdl/lps_ctrl.sv =====
// lps_ctrl: line state machine and stream handshake control
// issues load and step commands to lps_datapath and owns the output valid flag
// depends on lps_pkg
module lps_ctrl (
  input  logic                clk,
  input  logic                rst,
  input  logic                s_tvalid,
  output logic                s_tready,
  input  logic                s_func,
  output logic                m_tvalid,
  input  logic                m_tready,
  output lps_pkg::dp_cmd_t    cmd,
  input  lps_pkg::dp_status_t status
);

  lps_pkg::line_state_t state, state_next;
  logic out_valid, out_valid_next;
  logic accept;

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= lps_pkg::LN_IDLE;
      out_valid <= 1'b0;
    end else begin
      state     <= state_next;
      out_valid <= out_valid_next;
    end
  end

  // next state
  always_comb begin
    state_next = state;
    if (cmd.load) begin
      state_next = lps_pkg::LN_ACTIVE;
    end else if (cmd.step && status.last) begin
      state_next = lps_pkg::LN_IDLE;
    end
  end

  // outputs and commands
  always_comb begin
    s_tready = !out_valid || m_tready;
    accept   = s_tvalid && s_tready;
    cmd.load = accept && (s_func == lps_pkg::FUNC_LOAD);
    cmd.step = 1'b0;
    unique case (state)
      lps_pkg::LN_IDLE:   cmd.step = 1'b0;
      lps_pkg::LN_ACTIVE: cmd.step = accept && (s_func == lps_pkg::FUNC_STEP);
      default:            cmd.step = 1'b0;
    endcase
    if (cmd.step) begin
      out_valid_next = 1'b1;
    end else if (m_tready) begin
      out_valid_next = 1'b0;
    end else begin
      out_valid_next = out_valid;
    end
    m_tvalid = out_valid;
  end

endmodule

// ===== hdl/lps_datapath.sv =====
// lps_datapath: endpoint setup, incremental minor-axis stepping, bounds test,
// canvas registers and the output word register
// depends on lps_pkg; driven by lps_ctrl
module lps_datapath (
  input  logic                         clk,
  input  logic                         rst,
  input  lps_pkg::dp_cmd_t             cmd,
  output lps_pkg::dp_status_t          status,
  input  lps_pkg::coord_t              start_x,
  input  lps_pkg::coord_t              start_y,
  input  lps_pkg::coord_t              end_x,
  input  lps_pkg::coord_t              end_y,
  input  logic                         cfg_we,
  input  logic                         cfg_index,
  input  logic [lps_pkg::CFG_BITS-1:0] cfg_data,
  output lps_pkg::coord_t              pixel_x,
  output lps_pkg::coord_t              pixel_y,
  output logic                         pixel_inside,
  output logic                         last_pixel,
  output logic                         line_inside
);

  localparam int CB = lps_pkg::COORD_BITS;

  logic [lps_pkg::CFG_BITS-1:0] canvas_width, canvas_height;

  // line state
  lps_pkg::coord_t major_pos, target_major, origin_minor;
  logic [CB-1:0]   quot;       // |minor offset|
  logic [CB:0]     rem;        // numerator remainder, below 2*dmajor
  logic [CB-1:0]   dmajor;
  logic [CB-1:0]   dminor_abs;
  logic            minor_neg;
  logic            vertical;
  logic            all_inside;

  // setup
  logic signed [CB:0] dx, dy, dmj, dmn;
  logic [CB:0]        adx, ady, admj, admn;
  logic               vert_new, swap;
  lps_pkg::coord_t    a0, a1, b0, b1;

  always_comb begin
    dx   = {end_x[CB-1], end_x} - {start_x[CB-1], start_x};
    dy   = {end_y[CB-1], end_y} - {start_y[CB-1], start_y};
    adx  = dx[CB] ? (CB+1)'(-dx) : dx;
    ady  = dy[CB] ? (CB+1)'(-dy) : dy;
    vert_new = ady > adx;
    dmj  = vert_new ? dy : dx;
    dmn  = vert_new ? dx : dy;
    admj = vert_new ? ady : adx;
    admn = vert_new ? adx : ady;
    a0   = vert_new ? start_y : start_x;
    a1   = vert_new ? end_y   : end_x;
    b0   = vert_new ? start_x : start_y;
    b1   = vert_new ? end_x   : end_y;
    swap = dmj[CB];
  end

  // current pixel
  logic signed [CB:0] minor_wide;
  lps_pkg::coord_t    minor_cur, px, py;
  logic               inside_cur;
  logic [CB+1:0]      rem_sum, rem_diff, two_dmajor;
  logic               carry;

  always_comb begin
    if (minor_neg) begin
      minor_wide = {origin_minor[CB-1], origin_minor} - {1'b0, quot};
    end else begin
      minor_wide = {origin_minor[CB-1], origin_minor} + {1'b0, quot};
    end
    minor_cur = minor_wide[CB-1:0];
    px = vertical ? minor_cur : major_pos;
    py = vertical ? major_pos : minor_cur;
    inside_cur = !px[CB-1] && !py[CB-1]
              && (lps_pkg::CMP_BITS'(px) < lps_pkg::CMP_BITS'(canvas_width))
              && (lps_pkg::CMP_BITS'(py) < lps_pkg::CMP_BITS'(canvas_height));
    status.last = major_pos >= target_major;
    rem_sum    = {1'b0, rem} + {1'b0, dminor_abs, 1'b0};
    two_dmajor = {1'b0, dmajor, 1'b0};
    carry      = rem_sum >= two_dmajor;
    rem_diff   = rem_sum - two_dmajor;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      canvas_width  <= lps_pkg::CANVAS_WIDTH_RESET;
      canvas_height <= lps_pkg::CANVAS_HEIGHT_RESET;
      major_pos     <= '0;
      target_major  <= '0;
      origin_minor  <= '0;
      quot          <= '0;
      rem           <= '0;
      dmajor        <= '0;
      dminor_abs    <= '0;
      minor_neg     <= 1'b0;
      vertical      <= 1'b0;
      all_inside    <= 1'b1;
    end else begin
      if (cfg_we) begin
        unique case (cfg_index)
          lps_pkg::REG_CANVAS_WIDTH:  canvas_width  <= cfg_data;
          lps_pkg::REG_CANVAS_HEIGHT: canvas_height <= cfg_data;
          default: ;
        endcase
      end
      if (cmd.load) begin
        major_pos    <= swap ? a1 : a0;
        target_major <= swap ? a0 : a1;
        origin_minor <= swap ? b1 : b0;
        dmajor       <= admj[CB-1:0];
        dminor_abs   <= admn[CB-1:0];
        // minor direction after ordering the endpoints
        minor_neg    <= swap ? (!dmn[CB] && (dmn != '0)) : dmn[CB];
        vertical     <= vert_new;
        quot         <= '0;
        rem          <= {1'b0, admj[CB-1:0]};   // rounding bias of dmajor
        all_inside   <= 1'b1;
      end else if (cmd.step) begin
        all_inside <= all_inside && inside_cur;
        if (!status.last) begin
          major_pos <= major_pos + CB'(1);
          if (carry) begin
            rem  <= rem_diff[CB:0];
            quot <= quot + CB'(1);
          end else begin
            rem  <= rem_sum[CB:0];
          end
        end
      end
    end
  end

  // output word register, loaded on each step
  always_ff @(posedge clk) begin
    if (cmd.step) begin
      pixel_x      <= px;
      pixel_y      <= py;
      pixel_inside <= inside_cur;
      last_pixel   <= status.last;
      line_inside  <= all_inside && inside_cur;
    end
  end

endmodule

// ===== hdl/line_pixel_stepper.sv =====
// line_pixel_stepper: a load word (tuser 0) sets up a line and yields no output;
// each step word (tuser 1) accepted while a line is active yields one pixel word
// in the cycle after acceptance; throughput is one word per cycle while m_tready
// holds; input is taken while the output register is empty or drains.
// synchronous active-high reset: idle, canvas 640 x 480, no output pending
module line_pixel_stepper (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            s_tvalid,
  output logic                            s_tready,
  // start_x, start_y, end_x, end_y
  input  logic [lps_pkg::S_DATA_BITS-1:0] s_tdata,
  // func
  input  logic                            s_tuser,
  output logic                            m_tvalid,
  input  logic                            m_tready,
  // pixel_x, pixel_y, pixel_inside, line_inside, zero padding
  output logic [lps_pkg::M_DATA_BITS-1:0] m_tdata,
  // last_pixel
  output logic                            m_tlast,
  input  logic                            cfg_we,
  input  logic                            cfg_index,
  input  logic [lps_pkg::CFG_BITS-1:0]    cfg_data
);

  localparam int CB = lps_pkg::COORD_BITS;

  lps_pkg::dp_cmd_t    cmd;
  lps_pkg::dp_status_t status;
  lps_pkg::coord_t     pixel_x, pixel_y;
  logic                pixel_inside, line_inside;

  lps_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_func   (s_tuser),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .cmd      (cmd),
    .status   (status)
  );

  lps_datapath u_dp (
    .clk          (clk),
    .rst          (rst),
    .cmd          (cmd),
    .status       (status),
    .start_x      (s_tdata[CB-1:0]),
    .start_y      (s_tdata[2*CB-1:CB]),
    .end_x        (s_tdata[3*CB-1:2*CB]),
    .end_y        (s_tdata[4*CB-1:3*CB]),
    .cfg_we       (cfg_we),
    .cfg_index    (cfg_index),
    .cfg_data     (cfg_data),
    .pixel_x      (pixel_x),
    .pixel_y      (pixel_y),
    .pixel_inside (pixel_inside),
    .last_pixel   (m_tlast),
    .line_inside  (line_inside)
  );

  assign m_tdata = lps_pkg::M_DATA_BITS'({line_inside, pixel_inside, pixel_y, pixel_x});

endmodule

// ===== hdl/lps_checker.sv =====
// lps_checker: port-level assertions for line_pixel_stepper
// bound to the top level below; depends on lps_pkg
module lps_checker (
  input logic                            clk,
  input logic                            rst,
  input logic                            s_tvalid,
  input logic                            s_tready,
  input logic [lps_pkg::S_DATA_BITS-1:0] s_tdata,
  input logic                            s_tuser,
  input logic                            m_tvalid,
  input logic                            m_tready,
  input logic [lps_pkg::M_DATA_BITS-1:0] m_tdata,
  input logic                            m_tlast
);

  // a stalled output word holds
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tlast))
    else $error("output word changed while stalled");

  // running flag never claims inside when this pixel is outside
  a_line_inside: assert property (@(posedge clk) disable iff (rst)
    m_tvalid |-> !(m_tdata[lps_pkg::M_LINE_INSIDE_BIT]
                   && !m_tdata[lps_pkg::M_PIX_INSIDE_BIT]))
    else $error("line_inside set on an outside pixel");

  // input only back-pressures behind a pending output word
  a_ready: assert property (@(posedge clk) disable iff (rst)
    !s_tready |-> m_tvalid)
    else $error("input stalled with empty output");

  // reset drops any pending output
  a_reset: assert property (@(posedge clk)
    rst |=> !m_tvalid)
    else $error("output valid after reset");

  // a load word taken with no output pending produces no output
  a_load_silent: assert property (@(posedge clk) disable iff (rst)
    s_tvalid && s_tready && (s_tuser == lps_pkg::FUNC_LOAD) && !m_tvalid
    |=> !m_tvalid)
    else $error("output after a load word");

endmodule

bind line_pixel_stepper lps_checker u_lps_checker (.*);
